// ----- rtl/core/char_lcd_4bit_write_sequencer_macros.svh -----
// assertion macros for the character lcd write sequencer
// used by the top level only, no other dependencies
`ifndef CHAR_LCD_4BIT_WRITE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_4BIT_WRITE_SEQUENCER_MACROS_SVH

// same-cycle implication under the asynchronous reset
`define CLCD4_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("clcd4 check failed");

// next-cycle implication under the asynchronous reset
`define CLCD4_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("clcd4 check failed");

`endif

// ----- rtl/core/clcd4_pkg.sv -----
// shared types and codes for the character lcd 4-bit write sequencer
// no dependencies
package clcd4_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned OPCODE_W = 3;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [OPCODE_W-1:0] OP_TICK  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_CMD   = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_DATA  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_TEXT  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_SLOT  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUSY_TIMEOUT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LINE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CGRAM_BASE   = 2'd3;

	localparam logic [15:0] PULSE_TICKS_RST  = 16'd4;
	localparam logic [15:0] BUSY_TIMEOUT_RST = 16'd1000;
	localparam logic [7:0]  SECOND_LINE_RST  = 8'd192;
	localparam logic [7:0]  CGRAM_BASE_RST   = 8'd64;

	localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [BYTE_W-1:0] SLOT_COUNT   = 8'd8;
	localparam logic [2:0]        SLOT_MAX     = 3'd7;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_POLL  = 5'b00010,
		PH_SETUP = 5'b00100,
		PH_EN_HI = 5'b01000,
		PH_EN_LO = 5'b10000
	} phase_t;

	typedef struct packed {
		phase_t            phase;
		logic [BYTE_W-1:0] pending_byte;
		logic              select_data;
		logic              low_half;
		logic              enable_level;
	} state_t;

	typedef struct packed {
		logic [15:0] pulse_ticks;
		logic [15:0] busy_timeout;
		logic [7:0]  second_line_cmd;
		logic [7:0]  cgram_base;
	} cfg_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                done_res;
		logic                ready_res;
		logic                data_drive;
		logic [3:0]          data_nibble;
		logic                enable_line;
		logic                rw_line;
		logic                rs_line;
	} result_t;

endpackage

// ----- rtl/core/char_lcd_4bit_write_sequencer.sv -----
// top level of the character lcd 4-bit write sequencer: input register,
// sequencer state, output register and configuration registers
// depends on clcd4_pkg, clcd4_step and char_lcd_4bit_write_sequencer_macros.svh
// an accepted transaction passes the input register, then the output register
// throughput: one transaction per cycle unless the output stalls, limited by the single state update
// reset (arst_n low) clears the sequencer to idle, empties both registers
// and loads the configuration registers with their defaults
`include "char_lcd_4bit_write_sequencer_macros.svh"

module char_lcd_4bit_write_sequencer #(
	parameter int TICK_COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // byte_value[7:0], busy_pin[8], zero[15:9]
	input  logic [2:0]  s_axis_tuser,  // opcode[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// rs_line[0], rw_line[1], enable_line[2], data_nibble[6:3], data_drive[7],
	// ready_res[8], done_res[9], status[11:10], zero[15:12]
	output logic [15:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic                              s1_valid;
	logic [clcd4_pkg::OPCODE_W-1:0]    opcode_s1;
	logic [clcd4_pkg::BYTE_W-1:0]      byte_s1;
	logic                              busy_s1;
	logic                              advance;
	logic                              m_valid_q;
	clcd4_pkg::result_t                result_q;
	clcd4_pkg::result_t                result_nxt;
	clcd4_pkg::state_t                 state_q;
	clcd4_pkg::state_t                 state_nxt;
	logic [TICK_COUNT_BITS-1:0]        tick_q;
	logic [TICK_COUNT_BITS-1:0]        tick_nxt;
	clcd4_pkg::cfg_t                   cfg_q;
	logic                              ph_idle;
	logic                              ph_poll;
	logic                              idle_clear;
	logic                              done_clear;

	assign advance       = !m_valid_q || m_axis_tready;
	assign s_axis_tready = !s1_valid || advance;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {4'b0000, result_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_ticks     <= clcd4_pkg::PULSE_TICKS_RST;
			cfg_q.busy_timeout    <= clcd4_pkg::BUSY_TIMEOUT_RST;
			cfg_q.second_line_cmd <= clcd4_pkg::SECOND_LINE_RST;
			cfg_q.cgram_base      <= clcd4_pkg::CGRAM_BASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				clcd4_pkg::CFG_PULSE_TICKS:  cfg_q.pulse_ticks     <= cfg_data;
				clcd4_pkg::CFG_BUSY_TIMEOUT: cfg_q.busy_timeout    <= cfg_data;
				clcd4_pkg::CFG_SECOND_LINE:  cfg_q.second_line_cmd <= cfg_data[7:0];
				clcd4_pkg::CFG_CGRAM_BASE:   cfg_q.cgram_base      <= cfg_data[7:0];
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			opcode_s1 <= s_axis_tuser;
			byte_s1   <= s_axis_tdata[7:0];
			busy_s1   <= s_axis_tdata[8];
		end
	end

	clcd4_step #(
		.TICK_COUNT_BITS(TICK_COUNT_BITS)
	) u_step (
		.state      (state_q),
		.tick_count (tick_q),
		.cfg        (cfg_q),
		.opcode     (opcode_s1),
		.byte_value (byte_s1),
		.busy_pin   (busy_s1),
		.state_nxt  (state_nxt),
		.tick_nxt   (tick_nxt),
		.result     (result_nxt)
	);

	// sequencer state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase        <= clcd4_pkg::PH_IDLE;
			state_q.pending_byte <= '0;
			state_q.select_data  <= 1'b0;
			state_q.low_half     <= 1'b0;
			state_q.enable_level <= 1'b0;
			tick_q               <= '0;
			m_valid_q            <= 1'b0;
		end else if (s1_valid && advance) begin
			state_q   <= state_nxt;
			tick_q    <= tick_nxt;
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid && advance) begin
			result_q <= result_nxt;
		end
	end

	assign ph_idle    = (state_q.phase == clcd4_pkg::PH_IDLE);
	assign ph_poll    = (state_q.phase == clcd4_pkg::PH_POLL);
	assign idle_clear = (tick_q == '0) && !state_q.low_half && !state_q.enable_level;
	assign done_clear = result_q.ready_res && (result_q.status != clcd4_pkg::ST_REFUSED);

	`CLCD4_ASSERT_NOW(a_idle_quiet, clk, arst_n, ph_idle, idle_clear)
	`CLCD4_ASSERT_NOW(a_poll_enable, clk, arst_n, ph_poll, state_q.enable_level && !state_q.low_half)
	`CLCD4_ASSERT_NOW(a_done_ready, clk, arst_n, m_valid_q && result_q.done_res, done_clear)
	`CLCD4_ASSERT_NEXT(a_step_emits, clk, arst_n, s1_valid && advance, m_valid_q)

endmodule

// ----- rtl/core/clcd4_step.sv -----
// next-state and pin result logic for one transaction of the lcd sequencer
// depends on clcd4_pkg
module clcd4_step #(
	parameter int TICK_COUNT_BITS = 16
) (
	input  clcd4_pkg::state_t               state,
	input  logic [TICK_COUNT_BITS-1:0]      tick_count,
	input  clcd4_pkg::cfg_t                 cfg,
	input  logic [clcd4_pkg::OPCODE_W-1:0]  opcode,
	input  logic [clcd4_pkg::BYTE_W-1:0]    byte_value,
	input  logic                            busy_pin,
	output clcd4_pkg::state_t               state_nxt,
	output logic [TICK_COUNT_BITS-1:0]      tick_nxt,
	output clcd4_pkg::result_t              result
);

	localparam int CMP_W = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;
	localparam logic [TICK_COUNT_BITS-1:0] TICK_ONE = TICK_COUNT_BITS'(1);
	localparam logic [TICK_COUNT_BITS-1:0] TICK_ZERO = '0;
	localparam logic [TICK_COUNT_BITS-1:0] TICK_MAX = '1;

	logic [TICK_COUNT_BITS-1:0] tick_inc;
	logic                       pulse_over;
	logic                       poll_over;
	logic                       is_request;
	logic [2:0]                 slot;
	clcd4_pkg::state_t          req_state;

	// saturating counter; a saturated count also ends any interval
	assign tick_inc   = (tick_count == TICK_MAX) ? tick_count : tick_count + TICK_ONE;
	assign pulse_over = (CMP_W'(tick_count) >= CMP_W'(cfg.pulse_ticks)) ||
		(tick_count == TICK_MAX);
	assign poll_over  = (CMP_W'(tick_inc) >= CMP_W'(cfg.busy_timeout)) ||
		(tick_inc == TICK_MAX);

	assign is_request = (opcode == clcd4_pkg::OP_CMD) || (opcode == clcd4_pkg::OP_DATA) ||
		(opcode == clcd4_pkg::OP_TEXT) || (opcode == clcd4_pkg::OP_SLOT);
	assign slot = (byte_value >= clcd4_pkg::SLOT_COUNT) ? clcd4_pkg::SLOT_MAX : byte_value[2:0];

	always_comb begin
		req_state              = state;
		req_state.phase        = clcd4_pkg::PH_POLL;
		req_state.low_half     = 1'b0;
		req_state.enable_level = 1'b1;
		req_state.pending_byte = byte_value;
		req_state.select_data  = 1'b0;
		unique case (opcode)
			clcd4_pkg::OP_DATA: begin
				req_state.select_data = 1'b1;
			end
			clcd4_pkg::OP_TEXT: begin
				if (byte_value == clcd4_pkg::NEWLINE_CHAR) begin
					req_state.pending_byte = cfg.second_line_cmd;
				end else begin
					req_state.select_data = 1'b1;
				end
			end
			clcd4_pkg::OP_SLOT: begin
				req_state.pending_byte = cfg.cgram_base + {2'b00, slot, 3'b000};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_nxt       = state;
		tick_nxt        = tick_count;
		result.done_res = 1'b0;
		result.status   = clcd4_pkg::ST_OK;
		if (is_request) begin
			if (state.phase != clcd4_pkg::PH_IDLE) begin
				result.status = clcd4_pkg::ST_REFUSED;
			end else begin
				state_nxt = req_state;
				tick_nxt  = TICK_ZERO;
			end
		end else begin
			unique case (state.phase)
				clcd4_pkg::PH_IDLE: begin
				end
				clcd4_pkg::PH_POLL: begin
					if (!busy_pin) begin
						state_nxt.phase        = clcd4_pkg::PH_SETUP;
						state_nxt.enable_level = 1'b0;
						tick_nxt               = TICK_ZERO;
					end else if (poll_over) begin
						state_nxt.phase        = clcd4_pkg::PH_IDLE;
						state_nxt.enable_level = 1'b0;
						tick_nxt               = TICK_ZERO;
						result.done_res        = 1'b1;
						result.status          = clcd4_pkg::ST_TIMEOUT;
					end else begin
						tick_nxt = tick_inc;
					end
				end
				clcd4_pkg::PH_SETUP: begin
					state_nxt.phase        = clcd4_pkg::PH_EN_HI;
					state_nxt.enable_level = 1'b1;
					tick_nxt               = TICK_ONE;
				end
				clcd4_pkg::PH_EN_HI: begin
					if (pulse_over) begin
						state_nxt.phase        = clcd4_pkg::PH_EN_LO;
						state_nxt.enable_level = 1'b0;
						tick_nxt               = TICK_ONE;
					end else begin
						tick_nxt = tick_inc;
					end
				end
				clcd4_pkg::PH_EN_LO: begin
					if (pulse_over) begin
						if (!state.low_half) begin
							state_nxt.low_half     = 1'b1;
							state_nxt.phase        = clcd4_pkg::PH_EN_HI;
							state_nxt.enable_level = 1'b1;
							tick_nxt               = TICK_ONE;
						end else begin
							state_nxt.phase        = clcd4_pkg::PH_IDLE;
							state_nxt.low_half     = 1'b0;
							state_nxt.enable_level = 1'b0;
							tick_nxt               = TICK_ZERO;
							result.done_res        = 1'b1;
						end
					end else begin
						tick_nxt = tick_inc;
					end
				end
				default: begin
					state_nxt.phase        = clcd4_pkg::PH_IDLE;
					state_nxt.enable_level = 1'b0;
				end
			endcase
		end

		// pins as they stand after this transaction
		result.rw_line     = (state_nxt.phase == clcd4_pkg::PH_POLL);
		result.data_drive  = (state_nxt.phase != clcd4_pkg::PH_POLL);
		result.ready_res   = (state_nxt.phase == clcd4_pkg::PH_IDLE);
		result.enable_line = state_nxt.enable_level;
		if ((state_nxt.phase == clcd4_pkg::PH_IDLE) || (state_nxt.phase == clcd4_pkg::PH_POLL)) begin
			result.rs_line     = 1'b0;
			result.data_nibble = 4'h0;
		end else begin
			result.rs_line     = state_nxt.select_data;
			result.data_nibble = state_nxt.low_half ? state_nxt.pending_byte[3:0] :
				state_nxt.pending_byte[7:4];
		end
	end

endmodule

// ----- verif/tb.sv -----
// self-checking testbench for char_lcd_4bit_write_sequencer: directed rows, then random
// write sequences, each result checked against its typed pins or a pin-level model of the sequencer
// depends on clcd4_pkg and the rtl of the sequencer
module tb;

	localparam int STALL_LIMIT = 4000;
	localparam int SHOWN_MAX = 10;
	localparam logic [clcd4_pkg::OPCODE_W-1:0] OP_SPARE_FIRST = clcd4_pkg::OP_SLOT + 3'd1;
	localparam logic [clcd4_pkg::OPCODE_W-1:0] OP_SPARE_LAST = '1;
	localparam logic [15:0] TICK_SAT = '1;

	localparam clcd4_pkg::result_t IDLE_PINS = '{status: clcd4_pkg::ST_OK, done_res: 1'b0,
		ready_res: 1'b1, data_drive: 1'b1, data_nibble: 4'h0, enable_line: 1'b0,
		rw_line: 1'b0, rs_line: 1'b0};
	localparam clcd4_pkg::result_t POLL_PINS = '{status: clcd4_pkg::ST_OK, done_res: 1'b0,
		ready_res: 1'b0, data_drive: 1'b0, data_nibble: 4'h0, enable_line: 1'b1,
		rw_line: 1'b1, rs_line: 1'b0};
	localparam clcd4_pkg::result_t REFUSED_PINS = '{status: clcd4_pkg::ST_REFUSED,
		done_res: 1'b0, ready_res: 1'b0, data_drive: 1'b0, data_nibble: 4'h0,
		enable_line: 1'b1, rw_line: 1'b1, rs_line: 1'b0};
	localparam clcd4_pkg::result_t TIMEOUT_PINS = '{status: clcd4_pkg::ST_TIMEOUT,
		done_res: 1'b1, ready_res: 1'b1, data_drive: 1'b1, data_nibble: 4'h0,
		enable_line: 1'b0, rw_line: 1'b0, rs_line: 1'b0};
	localparam clcd4_pkg::result_t DONE_PINS = '{status: clcd4_pkg::ST_OK, done_res: 1'b1,
		ready_res: 1'b1, data_drive: 1'b1, data_nibble: 4'h0, enable_line: 1'b0,
		rw_line: 1'b0, rs_line: 1'b0};

	typedef struct {
		logic [clcd4_pkg::OPCODE_W-1:0] op;
		logic [clcd4_pkg::BYTE_W-1:0]   val;
		logic                           busy;
		bit                             typed;
		clcd4_pkg::result_t             pins;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // byte_value[7:0], busy_pin[8], zero[15:9]
	logic [2:0]  s_axis_tuser = '0;  // opcode[2:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// rs_line[0], rw_line[1], enable_line[2], data_nibble[6:3], data_drive[7],
	// ready_res[8], done_res[9], status[11:10], zero[15:12]
	logic [15:0] m_axis_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	char_lcd_4bit_write_sequencer u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// model of the sequencer: state and register copies
	clcd4_pkg::phase_t ph = clcd4_pkg::PH_IDLE;
	logic [7:0]  pend = '0;
	logic        sel = 1'b0;
	logic        lowh = 1'b0;
	logic        enl = 1'b0;
	logic [15:0] tcnt = '0;
	logic [15:0] c_pulse = clcd4_pkg::PULSE_TICKS_RST;
	logic [15:0] c_timeout = clcd4_pkg::BUSY_TIMEOUT_RST;
	logic [7:0]  c_second = clcd4_pkg::SECOND_LINE_RST;
	logic [7:0]  c_base = clcd4_pkg::CGRAM_BASE_RST;

	clcd4_pkg::result_t exp_pins_q[$];
	int      mismatches = 0;
	int      result_cnt = 0;
	int      idle_cycles = 0;
	bit      quiet = 1'b0;
	bit      hold_req = 1'b0;
	int      busy_left = 0;
	clcd4_pkg::result_t got_pins;
	clcd4_pkg::result_t want_pins;

	function automatic void tick_up();
		if (tcnt != TICK_SAT)
			tcnt++;
	endfunction

	// a saturated count also ends the interval
	function automatic bit span_over(logic [15:0] limit);
		return (tcnt >= limit) || (tcnt == TICK_SAT);
	endfunction

	function automatic clcd4_pkg::result_t lcd_advance(logic [2:0] op, logic [7:0] val,
			logic busy);
		logic               done;
		logic [1:0]         st;
		logic [2:0]         slot;
		clcd4_pkg::result_t pins;
		done = 1'b0;
		st = clcd4_pkg::ST_OK;
		if (op >= clcd4_pkg::OP_CMD && op <= clcd4_pkg::OP_SLOT) begin
			if (ph != clcd4_pkg::PH_IDLE) begin
				st = clcd4_pkg::ST_REFUSED;
			end else begin
				unique case (op)
				clcd4_pkg::OP_CMD: begin
					pend = val;
					sel = 1'b0;
				end
				clcd4_pkg::OP_DATA: begin
					pend = val;
					sel = 1'b1;
				end
				clcd4_pkg::OP_TEXT: begin
					if (val == clcd4_pkg::NEWLINE_CHAR) begin
						pend = c_second;
						sel = 1'b0;
					end else begin
						pend = val;
						sel = 1'b1;
					end
				end
				default: begin
					slot = (val >= clcd4_pkg::SLOT_COUNT) ? clcd4_pkg::SLOT_MAX : val[2:0];
					pend = 8'(c_base + clcd4_pkg::SLOT_COUNT * slot);
					sel = 1'b0;
				end
				endcase
				ph = clcd4_pkg::PH_POLL;
				tcnt = '0;
				lowh = 1'b0;
				enl = 1'b1;
			end
		end else begin
			unique case (ph)
			clcd4_pkg::PH_POLL: begin
				if (!busy) begin
					ph = clcd4_pkg::PH_SETUP;
					enl = 1'b0;
					tcnt = '0;
				end else begin
					tick_up();
					if (span_over(c_timeout)) begin
						ph = clcd4_pkg::PH_IDLE;
						enl = 1'b0;
						tcnt = '0;
						done = 1'b1;
						st = clcd4_pkg::ST_TIMEOUT;
					end
				end
			end
			clcd4_pkg::PH_SETUP: begin
				ph = clcd4_pkg::PH_EN_HI;
				enl = 1'b1;
				tcnt = 16'd1;
			end
			clcd4_pkg::PH_EN_HI: begin
				if (span_over(c_pulse)) begin
					ph = clcd4_pkg::PH_EN_LO;
					enl = 1'b0;
					tcnt = 16'd1;
				end else begin
					tick_up();
				end
			end
			clcd4_pkg::PH_EN_LO: begin
				if (span_over(c_pulse)) begin
					if (!lowh) begin
						lowh = 1'b1;
						ph = clcd4_pkg::PH_EN_HI;
						enl = 1'b1;
						tcnt = 16'd1;
					end else begin
						ph = clcd4_pkg::PH_IDLE;
						lowh = 1'b0;
						enl = 1'b0;
						tcnt = '0;
						done = 1'b1;
					end
				end else begin
					tick_up();
				end
			end
			default: begin
				ph = clcd4_pkg::PH_IDLE;
				enl = 1'b0;
			end
			endcase
		end
		pins = '0;
		pins.enable_line = enl;
		pins.done_res = done;
		pins.status = st;
		pins.ready_res = (ph == clcd4_pkg::PH_IDLE);
		pins.data_drive = 1'b1;
		if (ph == clcd4_pkg::PH_POLL) begin
			pins.rw_line = 1'b1;
			pins.data_drive = 1'b0;
		end else if (ph != clcd4_pkg::PH_IDLE) begin
			pins.rs_line = sel;
			pins.data_nibble = lowh ? pend[3:0] : pend[7:4];
		end
		return pins;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic string fmt_pins(clcd4_pkg::result_t p);
		return $sformatf("rs=%0d rw=%0d en=%0d nib=%h drive=%0d ready=%0d done=%0d status=%0d",
			p.rs_line, p.rw_line, p.enable_line, p.data_nibble, p.data_drive,
			p.ready_res, p.done_res, p.status);
	endfunction

	// drives one item and waits for its transaction; typed rows carry their own expectation
	task automatic send_item(logic [2:0] op, logic [7:0] val, logic busy, bit typed,
			clcd4_pkg::result_t typed_pins);
		int                 gap;
		clcd4_pkg::result_t pins;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {7'b0, busy, val};
		do @(posedge clk); while (!s_axis_tready);
		pins = lcd_advance(op, val, busy);
		exp_pins_q.push_back(typed ? typed_pins : pins);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (exp_pins_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		unique case (idx)
		clcd4_pkg::CFG_PULSE_TICKS:  c_pulse = data;
		clcd4_pkg::CFG_BUSY_TIMEOUT: c_timeout = data;
		clcd4_pkg::CFG_SECOND_LINE:  c_second = data[7:0];
		default:                     c_base = data[7:0];
		endcase
	endtask

	task automatic send_request();
		logic [2:0] op;
		logic [7:0] val;
		int         r;
		op = 3'($urandom_range(clcd4_pkg::OP_CMD, clcd4_pkg::OP_SLOT));
		r = $urandom_range(0, 99);
		val = 8'($urandom_range(0, 255));
		if (op == clcd4_pkg::OP_TEXT && r < 30)
			val = clcd4_pkg::NEWLINE_CHAR;
		else if (op == clcd4_pkg::OP_SLOT && r < 70)
			val = 8'($urandom_range(0, clcd4_pkg::SLOT_MAX));
		else if (op == clcd4_pkg::OP_SLOT && r < 90)
			val = 8'($urandom_range(clcd4_pkg::SLOT_COUNT, 2 * clcd4_pkg::SLOT_COUNT - 1));
		if (ph == clcd4_pkg::PH_IDLE) begin
			r = $urandom_range(0, 99);
			if (r < 40)
				busy_left = 0;
			else if (r < 80)
				busy_left = $urandom_range(1, 4);
			else
				busy_left = $urandom_range(1, (c_timeout + 1 < 24) ? c_timeout + 1 : 24);
		end
		send_item(op, val, 1'b0, 1'b0, IDLE_PINS);
	endtask

	// mostly well-formed writes: request, busy samples, ticks to the end, some noise
	task automatic run_random(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				send_item(3'($urandom_range(0, OP_SPARE_LAST)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'b0, IDLE_PINS);
			end else if (ph == clcd4_pkg::PH_IDLE) begin
				if (r < 70)
					send_request();
				else if (r < 90)
					send_item(clcd4_pkg::OP_TICK, 8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), 1'b0, IDLE_PINS);
				else
					send_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)),
						8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
						IDLE_PINS);
			end else if (r < 12) begin
				send_request();
			end else if (ph == clcd4_pkg::PH_POLL) begin
				send_item(r < 16 ? OP_SPARE_FIRST : clcd4_pkg::OP_TICK,
					8'($urandom_range(0, 255)), busy_left > 0, 1'b0, IDLE_PINS);
				if (busy_left > 0)
					busy_left--;
			end else begin
				send_item(r < 18 ? OP_SPARE_LAST : clcd4_pkg::OP_TICK,
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, IDLE_PINS);
			end
		end
	endtask

	task automatic run_phase(logic [15:0] pulse, logic [15:0] tmo, logic [7:0] second,
			logic [7:0] base, int count, bit no_gaps, bit long_hold);
		drain();
		cfg_write(clcd4_pkg::CFG_PULSE_TICKS, pulse);
		cfg_write(clcd4_pkg::CFG_BUSY_TIMEOUT, tmo);
		cfg_write(clcd4_pkg::CFG_SECOND_LINE, {8'h00, second});
		cfg_write(clcd4_pkg::CFG_CGRAM_BASE, {8'h00, base});
		cfg_we <= 1'b0;
		quiet = no_gaps;
		hold_req = long_hold;
		run_random(count);
	endtask

	dir_row_t dir_rows[28];

	initial begin
		dir_rows = '{
			'{clcd4_pkg::OP_TICK, 8'h00, 1'b0, 1'b1, IDLE_PINS},
			'{OP_SPARE_FIRST,     8'h00, 1'b1, 1'b1, IDLE_PINS},
			'{OP_SPARE_LAST,      8'hFF, 1'b1, 1'b1, IDLE_PINS},
			'{clcd4_pkg::OP_CMD,  8'hFF, 1'b0, 1'b1, POLL_PINS},
			'{clcd4_pkg::OP_DATA, 8'h00, 1'b0, 1'b1, REFUSED_PINS},
			'{clcd4_pkg::OP_TICK, 8'h00, 1'b1, 1'b0, IDLE_PINS},
			'{clcd4_pkg::OP_TICK, 8'hFF, 1'b1, 1'b1, TIMEOUT_PINS},
			// newline goes out as the second-line command
			'{clcd4_pkg::OP_TEXT, clcd4_pkg::NEWLINE_CHAR, 1'b0, 1'b1, POLL_PINS},
			'{clcd4_pkg::OP_SLOT, 8'h00, 1'b1, 1'b1, REFUSED_PINS},
			'{clcd4_pkg::OP_TICK, 8'h00, 1'b0, 1'b0, IDLE_PINS},
			'{clcd4_pkg::OP_TICK, 8'h00, 1'b1, 1'b0, IDLE_PINS},
			'{clcd4_pkg::OP_TICK, 8'hFF, 1'b0, 1'b0, IDLE_PINS},
			'{clcd4_pkg::OP_TICK, 8'h00, 1'b1, 1'b0, IDLE_PINS},
			'{OP_SPARE_LAST - 3'd1, 8'h55, 1'b0, 1'b0, IDLE_PINS},
			'{clcd4_pkg::OP_TICK, 8'h00, 1'b0, 1'b1, DONE_PINS},
			'{clcd4_pkg::OP_DATA, 8'h80, 1'b1, 1'b1, POLL_PINS},
			'{clcd4_pkg::OP_TICK, 8'h00, 1'b1, 1'b0, IDLE_PINS},
			'{clcd4_pkg::OP_TICK, 8'h00, 1'b1, 1'b1, TIMEOUT_PINS},
			'{clcd4_pkg::OP_TEXT, 8'h41, 1'b0, 1'b1, POLL_PINS},
			'{clcd4_pkg::OP_TICK, 8'h00, 1'b1, 1'b0, IDLE_PINS},
			'{clcd4_pkg::OP_TICK, 8'h00, 1'b1, 1'b1, TIMEOUT_PINS},
			// slot number above the last slot is clamped
			'{clcd4_pkg::OP_SLOT, 8'hFF, 1'b0, 1'b1, POLL_PINS},
			'{clcd4_pkg::OP_TICK, 8'h00, 1'b0, 1'b0, IDLE_PINS},
			'{clcd4_pkg::OP_TICK, 8'h00, 1'b0, 1'b0, IDLE_PINS},
			'{clcd4_pkg::OP_TICK, 8'h00, 1'b0, 1'b0, IDLE_PINS},
			'{clcd4_pkg::OP_TICK, 8'h00, 1'b0, 1'b0, IDLE_PINS},
			'{clcd4_pkg::OP_TICK, 8'h00, 1'b0, 1'b0, IDLE_PINS},
			'{clcd4_pkg::OP_TICK, 8'h00, 1'b0, 1'b1, DONE_PINS}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// short pulses and timeout keep the directed writes brief
		cfg_write(clcd4_pkg::CFG_PULSE_TICKS, 16'd1);
		cfg_write(clcd4_pkg::CFG_BUSY_TIMEOUT, 16'd2);
		cfg_we <= 1'b0;
		foreach (dir_rows[i])
			send_item(dir_rows[i].op, dir_rows[i].val, dir_rows[i].busy, dir_rows[i].typed,
				dir_rows[i].pins);

		run_phase(clcd4_pkg::PULSE_TICKS_RST, clcd4_pkg::BUSY_TIMEOUT_RST,
			clcd4_pkg::SECOND_LINE_RST, clcd4_pkg::CGRAM_BASE_RST, 300, 1'b0, 1'b0);
		run_phase(16'd1, 16'd1, 8'h00, 8'hFF, 250, 1'b1, 1'b0);
		// top of the timing register ranges: writes stall in the pulse, refusals pile up
		run_phase(16'hFFFF, 16'hFFFF, 8'hFF, 8'h00, 60, 1'b0, 1'b0);
		// zero registers act as one
		run_phase(16'd0, 16'd0, clcd4_pkg::NEWLINE_CHAR, 8'hF8, 250, 1'b0, 1'b0);
		run_phase(16'd3, 16'd6, 8'h80, 8'h48, 300, 1'b0, 1'b1);
		run_phase(16'd2, 16'd3, 8'h94, 8'hC0, 260, 1'b0, 1'b0);

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && exp_pins_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = $urandom_range(100, 140);
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_pins = m_axis_tdata[11:0];
			result_cnt++;
			if (exp_pins_q.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MAX)
					$display("result %0d with nothing expected: %s", result_cnt,
						fmt_pins(got_pins));
			end else begin
				want_pins = exp_pins_q.pop_front();
				if (got_pins.rs_line !== want_pins.rs_line
						|| got_pins.rw_line !== want_pins.rw_line
						|| got_pins.enable_line !== want_pins.enable_line
						|| got_pins.data_nibble !== want_pins.data_nibble
						|| got_pins.data_drive !== want_pins.data_drive
						|| got_pins.ready_res !== want_pins.ready_res
						|| got_pins.done_res !== want_pins.done_res
						|| got_pins.status !== want_pins.status
						|| m_axis_tdata[15:12] !== 4'h0) begin
					mismatches++;
					if (mismatches <= SHOWN_MAX)
						$display("result %0d mismatch\n  expected %s\n  actual   %s pad=%h",
							result_cnt, fmt_pins(want_pins), fmt_pins(got_pins),
							m_axis_tdata[15:12]);
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/clcd4_pkg.sv
rtl/core/clcd4_step.sv
rtl/core/char_lcd_4bit_write_sequencer.sv
verif/tb.sv
